FILE: hdl/abkf_pkg.sv
package abkf_pkg;

   // Fraction bits of the sample interval; dt products are rounded at this point.
   localparam int DT_FRAC = 16;

   // Configuration register indexes.
   localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
   localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

   localparam logic [30:0] ANGLE_NOISE_RESET = 31'd16777;
   localparam logic [30:0] BIAS_NOISE_RESET  = 31'd50332;
   localparam logic [30:0] MEAS_NOISE_RESET  = 31'd503316;

   // Number of corrections that go through the divider.
   localparam int NUM_QUOT = 6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_RATE,
      OP_MUL_RATE,
      OP_ANGLE,
      OP_MUL_P11,
      OP_DP11,
      OP_INNER,
      OP_MUL_INNER,
      OP_PRED_COV,
      OP_MUL_QB,
      OP_PRED_P11,
      OP_MUL_CORR,
      OP_DIV_STORE,
      OP_APPLY,
      OP_OUT
   } abkf_op_type;

   typedef struct packed {
      abkf_op_type op;
      logic [2:0]  sel;
      logic        load_in;
      logic        cfg_we;
      logic        div_start;
   } abkf_cmd_type;

   typedef struct packed {
      logic s_zero;
      logic div_done;
   } abkf_status_type;

endpackage

FILE: hdl/abkf_div.sv
module abkf_div
   import abkf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [65:0] dividend,
   input  logic signed [32:0] divisor,
   output logic               done,
   output logic signed [65:0] quotient
);

   // Restoring divider on magnitudes, one quotient bit per cycle, truncating toward zero.
   logic [64:0] quo_ff;
   logic [33:0] rem_ff;
   logic [32:0] dvs_ff;
   logic        neg_ff;
   logic [6:0]  count_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [65:0] dvd_abs;
   logic [32:0] dvs_abs;
   logic [33:0] rem_sh;
   logic [34:0] diff;

   assign dvd_abs = dividend[65] ? 66'(-dividend) : 66'(dividend);
   assign dvs_abs = divisor[32] ? 33'(-divisor) : 33'(divisor);
   assign rem_sh  = {rem_ff[32:0], quo_ff[64]};
   assign diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 7'd1;
            if (count_ff == 7'd64) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dvd_abs[64:0];
         rem_ff <= '0;
         dvs_ff <= dvs_abs;
         neg_ff <= dividend[65] ^ divisor[32];
      end else if (busy_ff) begin
         if (!diff[34]) begin
            rem_ff <= diff[33:0];
         end else begin
            rem_ff <= rem_sh;
         end
         quo_ff <= {quo_ff[63:0], ~diff[34]};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

FILE: hdl/abkf_dpath.sv
module abkf_dpath
   import abkf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  abkf_cmd_type    cmd,
   output abkf_status_type status,
   input  logic [31:0]     in_angle,
   input  logic [31:0]     in_rate,
   input  logic [15:0]     in_interval,
   input  logic [1:0]      csr_index,
   input  logic [30:0]     csr_wdata,
   output logic [31:0]     out_angle,
   output logic [31:0]     out_bias,
   output logic [31:0]     out_rate
);

   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      if (x > 36'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (x < -36'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return x[31:0];
      end
   endfunction

   function automatic logic signed [33:0] clamp34(input logic signed [65:0] x);
      if (x > 66'sd8589934591) begin
         return 34'sh1FFFFFFFF;
      end else if (x < -66'sd8589934592) begin
         return 34'sh200000000;
      end else begin
         return x[33:0];
      end
   endfunction

   logic signed [31:0] angle_ff, bias_ff, rate_ff;
   logic signed [31:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [30:0]        qa_ff, qb_ff, r_ff;
   logic signed [31:0] z_ff, w_ff;
   logic [15:0]        dt_ff;
   logic signed [32:0] dp11_ff;
   logic signed [33:0] inner_ff;
   logic signed [32:0] s_ff, y_ff;
   logic signed [65:0] prod_ff;
   logic signed [33:0] quot_ff [NUM_QUOT];
   logic [31:0]        out_angle_ff, out_bias_ff, out_rate_ff;

   logic signed [33:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod_rnd;
   logic signed [65:0] prod_shr;
   logic signed [35:0] rnd36;
   logic               div_done;
   logic signed [65:0] div_quot;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = 34'(p00_ff);
      mul_b = 33'(signed'({1'b0, dt_ff}));
      case (cmd.op)
         OP_MUL_RATE:  mul_a = 34'(rate_ff);
         OP_MUL_P11:   mul_a = 34'(p11_ff);
         OP_MUL_INNER: mul_a = inner_ff;
         OP_MUL_QB:    mul_a = 34'(signed'({1'b0, qb_ff}));
         OP_MUL_CORR: begin
            case (cmd.sel)
               3'd0: begin mul_a = 34'(p00_ff); mul_b = y_ff;         end
               3'd1: begin mul_a = 34'(p10_ff); mul_b = y_ff;         end
               3'd2: begin mul_a = 34'(p00_ff); mul_b = 33'(p00_ff);  end
               3'd3: begin mul_a = 34'(p00_ff); mul_b = 33'(p01_ff);  end
               3'd4: begin mul_a = 34'(p10_ff); mul_b = 33'(p00_ff);  end
               default: begin mul_a = 34'(p10_ff); mul_b = 33'(p01_ff); end
            endcase
         end
         default: ;
      endcase
   end

   // Round half up on the dt products.
   assign prod_rnd = prod_ff + 66'sd32768;
   assign prod_shr = prod_rnd >>> DT_FRAC;
   assign rnd36    = prod_shr[35:0];

   abkf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (s_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         bias_ff  <= '0;
         rate_ff  <= '0;
         p00_ff   <= '0;
         p01_ff   <= '0;
         p10_ff   <= '0;
         p11_ff   <= '0;
         qa_ff    <= ANGLE_NOISE_RESET;
         qb_ff    <= BIAS_NOISE_RESET;
         r_ff     <= MEAS_NOISE_RESET;
      end else if (cmd.cfg_we) begin
         if (csr_index inside {REG_ANGLE_NOISE, REG_BIAS_NOISE, REG_MEAS_NOISE}) begin
            angle_ff <= '0;
            bias_ff  <= '0;
            rate_ff  <= '0;
            p00_ff   <= '0;
            p01_ff   <= '0;
            p10_ff   <= '0;
            p11_ff   <= '0;
         end
         case (csr_index)
            REG_ANGLE_NOISE: qa_ff <= csr_wdata;
            REG_BIAS_NOISE:  qb_ff <= csr_wdata;
            REG_MEAS_NOISE:  r_ff  <= csr_wdata;
            default: ;
         endcase
      end else begin
         case (cmd.op)
            OP_RATE:  rate_ff  <= sat32(36'(w_ff) - 36'(bias_ff));
            OP_ANGLE: angle_ff <= sat32(36'(angle_ff) + rnd36);
            OP_PRED_COV: begin
               p00_ff <= sat32(36'(p00_ff) + rnd36);
               p01_ff <= sat32(36'(p01_ff) - 36'(dp11_ff));
               p10_ff <= sat32(36'(p10_ff) - 36'(dp11_ff));
            end
            OP_PRED_P11: p11_ff <= sat32(36'(p11_ff) + rnd36);
            OP_APPLY: begin
               angle_ff <= sat32(36'(angle_ff) + 36'(quot_ff[0]));
               bias_ff  <= sat32(36'(bias_ff) + 36'(quot_ff[1]));
               p00_ff   <= sat32(36'(p00_ff) - 36'(quot_ff[2]));
               p01_ff   <= sat32(36'(p01_ff) - 36'(quot_ff[3]));
               p10_ff   <= sat32(36'(p10_ff) - 36'(quot_ff[4]));
               p11_ff   <= sat32(36'(p11_ff) - 36'(quot_ff[5]));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         z_ff  <= in_angle;
         w_ff  <= in_rate;
         dt_ff <= in_interval;
      end
      if (cmd.op == OP_MUL_RATE || cmd.op == OP_MUL_P11 || cmd.op == OP_MUL_INNER ||
          cmd.op == OP_MUL_QB || cmd.op == OP_MUL_CORR) begin
         prod_ff <= 66'(mul_a) * 66'(mul_b);
      end
      if (cmd.op == OP_DP11) begin
         dp11_ff <= rnd36[32:0];
      end
      if (cmd.op == OP_INNER) begin
         inner_ff <= 34'(dp11_ff) - 34'(p01_ff) - 34'(p10_ff)
                     + 34'(signed'({1'b0, qa_ff}));
      end
      if (cmd.op == OP_PRED_P11) begin
         s_ff <= 33'(p00_ff) + 33'(signed'({1'b0, r_ff}));
         y_ff <= 33'(z_ff) - 33'(angle_ff);
      end
      if (cmd.op == OP_DIV_STORE) begin
         quot_ff[cmd.sel] <= clamp34(div_quot);
      end
      if (cmd.op == OP_OUT) begin
         out_angle_ff <= angle_ff;
         out_bias_ff  <= bias_ff;
         out_rate_ff  <= rate_ff;
      end
   end

   assign status.s_zero   = (s_ff == 33'sd0);
   assign status.div_done = div_done;
   assign out_angle = out_angle_ff;
   assign out_bias  = out_bias_ff;
   assign out_rate  = out_rate_ff;

endmodule

FILE: hdl/abkf_ctrl.sv
module abkf_ctrl
   import abkf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  logic            csr_valid,
   output logic            csr_ready,
   output abkf_cmd_type    cmd,
   input  abkf_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_CHECK,
      ST_MUL,
      ST_DSTART,
      ST_DWAIT,
      ST_APPLY,
      ST_FINISH
   } state_type;

   state_type   state_ff, state_in;
   abkf_op_type step_ff, step_in;
   logic [2:0]  quot_ff, quot_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        finish_now;

   assign finish_now = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '{op: OP_NONE, sel: quot_ff, load_in: 1'b0,
                       cfg_we: 1'b0, div_start: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            cmd.cfg_we = csr_valid;
            if (req_valid && !csr_valid) begin
               cmd.load_in = 1'b1;
               step_in     = OP_RATE;
               state_in    = ST_PRED;
            end
         end
         ST_PRED: begin
            cmd.op  = step_ff;
            step_in = abkf_op_type'(step_ff + 4'd1);
            if (step_ff == OP_PRED_P11) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            quot_in  = '0;
            state_in = status.s_zero ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL_CORR;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (status.div_done) begin
               cmd.op = OP_DIV_STORE;
               if (quot_ff == 3'(NUM_QUOT - 1)) begin
                  state_in = ST_APPLY;
               end else begin
                  quot_in  = quot_ff + 3'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_APPLY: begin
            cmd.op   = OP_APPLY;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_now) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= OP_NONE;
         quot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         quot_ff      <= quot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/angle_bias_kalman_filter_top.sv
// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_stall  measured angle, measured rate, sample interval
// rsp_      out        rsp_valid/rsp_stall  angle estimate, bias estimate, corrected rate
// csr_      in         csr_valid/csr_ready  noise register index and 31-bit value
//
// A sample goes through prediction and the zero check, then through six corrections, where
// the 65-step radix-2 divider sets the pace, and then the update is applied and the result
// registered. A new sample is taken only once the controller is back in idle.
// With a zero innovation covariance the corrections are skipped.
// Reset is synchronous and active high; it clears the filter state and loads the default
// noise values. A stalled result waits in its output register while the next beat runs.
module angle_bias_kalman_filter_top
   import abkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_measured_angle,
   input  logic [31:0] req_measured_rate,
   input  logic [15:0] req_sample_interval,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_angle_estimate,
   output logic [31:0] rsp_bias_estimate,
   output logic [31:0] rsp_corrected_rate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   // The controller steps through the predict and correct sequence and drives
   // one command per cycle; the datapath holds the state and the shared
   // multiplier and divider.
   abkf_cmd_type    cmd;
   abkf_status_type status;

   abkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   abkf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_angle    (req_measured_angle),
      .in_rate     (req_measured_rate),
      .in_interval (req_sample_interval),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .out_angle   (rsp_angle_estimate),
      .out_bias    (rsp_bias_estimate),
      .out_rate    (rsp_corrected_rate)
   );

endmodule

FILE: tb/sv/angle_bias_kalman_filter_top_test.sv
`timescale 1ns / 1ps

// This bench runs the angle and gyro-bias filter through a short table of directed
// beats and then several phases of random samples. Each phase starts with new noise
// settings. Every accepted input beat is run through a local copy of the filter,
// which gives the expected result unless the table types one in. Every accepted
// output beat is then checked against the oldest expected result that is waiting.
module angle_bias_kalman_filter_top_test
   import abkf_pkg::*;
();

   localparam int          CYCLE_LIMIT  = 2000000;
   localparam int          HOLD_CYCLES  = 3000;
   localparam int          DRAIN_CYCLES = 600;
   localparam int          NUM_PHASES   = 6;
   localparam int          PHASE_ITEMS  = 115;
   // The index port is two bits wide, so one index selects no register at all.
   localparam logic [1:0]  REG_UNUSED   = 2'd3;
   localparam logic [30:0] NOISE_MAX    = 31'h7fffffff;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [31:0] angle;
      logic [31:0] bias;
      logic [31:0] rate;
   } filter_out_type;

   typedef struct {
      row_kind_type   kind;
      logic [1:0]     index;
      logic [30:0]    wdata;
      logic [31:0]    angle;
      logic [31:0]    rate;
      logic [15:0]    dt;
      bit             typed;
      filter_out_type result;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_measured_angle;
   logic [31:0] req_measured_rate;
   logic [15:0] req_sample_interval;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_angle_estimate;
   logic [31:0] rsp_bias_estimate;
   logic [31:0] rsp_corrected_rate;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [30:0] csr_wdata;

   // The result that is typed into the table rides along with the beat that causes it.
   logic           drv_typed;
   filter_out_type drv_result;

   angle_bias_kalman_filter_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_measured_angle (req_measured_angle),
      .req_measured_rate  (req_measured_rate),
      .req_sample_interval(req_sample_interval),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_angle_estimate (rsp_angle_estimate),
      .rsp_bias_estimate  (rsp_bias_estimate),
      .rsp_corrected_rate (rsp_corrected_rate),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Local copy of the noise settings and of the filter state.
   logic [30:0]        noise_angle;
   logic [30:0]        noise_bias;
   logic [30:0]        noise_meas;
   logic signed [31:0] est_angle;
   logic signed [31:0] est_bias;
   logic signed [31:0] est_rate;
   logic signed [31:0] cov00;
   logic signed [31:0] cov01;
   logic signed [31:0] cov10;
   logic signed [31:0] cov11;

   filter_out_type estimate_q[$];
   int             err_count;
   int unsigned    cycle_count;
   bit             hold_go;

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (x < -longint'(64'sd2147483648)) return 32'sh80000000;
      return x[31:0];
   endfunction

   // Scales a value by the sample interval. The product is rounded half up at the
   // binary point of dt, and the arithmetic shift takes the floor of negative values.
   function automatic longint scale_dt(input longint a, input logic [15:0] dt);
      longint p;
      p = a * longint'({48'd0, dt}) + (longint'(1) <<< (DT_FRAC - 1));
      return p >>> DT_FRAC;
   endfunction

   task automatic clear_filter();
      est_angle = '0;
      est_bias  = '0;
      est_rate  = '0;
      cov00     = '0;
      cov01     = '0;
      cov10     = '0;
      cov11     = '0;
   endtask

   // Runs a predict step and, if the innovation covariance is nonzero, a correct step.
   function automatic filter_out_type filter_step(input logic [31:0] z_in,
                                                  input logic [31:0] w_in,
                                                  input logic [15:0] dt);
      longint         p00, p01, p10, p11, dp11, inner, s, y;
      filter_out_type res;
      est_rate  = clamp32(longint'($signed(w_in)) - longint'(est_bias));
      est_angle = clamp32(longint'(est_angle) + scale_dt(longint'(est_rate), dt));
      p00   = cov00;
      p01   = cov01;
      p10   = cov10;
      p11   = cov11;
      dp11  = scale_dt(p11, dt);
      inner = dp11 - p01 - p10 + longint'({33'd0, noise_angle});
      cov00 = clamp32(p00 + scale_dt(inner, dt));
      cov01 = clamp32(p01 - dp11);
      cov10 = clamp32(p10 - dp11);
      cov11 = clamp32(p11 + scale_dt(longint'({33'd0, noise_bias}), dt));
      p00 = cov00;
      p01 = cov01;
      p10 = cov10;
      p11 = cov11;
      s   = p00 + longint'({33'd0, noise_meas});
      // A zero innovation covariance means zero gains, so the prediction stands.
      if (s != 0) begin
         y = longint'($signed(z_in)) - longint'(est_angle);
         est_angle = clamp32(longint'(est_angle) + (p00 * y) / s);
         est_bias  = clamp32(longint'(est_bias) + (p10 * y) / s);
         cov00     = clamp32(p00 - (p00 * p00) / s);
         cov01     = clamp32(p01 - (p00 * p01) / s);
         cov10     = clamp32(p10 - (p10 * p00) / s);
         cov11     = clamp32(p11 - (p10 * p01) / s);
      end
      res.angle = est_angle;
      res.bias  = est_bias;
      res.rate  = est_rate;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want,
               cycle_count);
      err_count++;
   endtask

   // All three channels are watched here on the same edges at which the beats move.
   // An accepted input beat advances the local filter, and the expectation is
   // queued right away. A register write changes the local settings, and it
   // clears the state unless the index selects nothing.
   always @(posedge clock) begin
      filter_out_type want;
      filter_out_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = filter_step(req_measured_angle, req_measured_rate, req_sample_interval);
            if (drv_typed) want = drv_result;
            estimate_q.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ANGLE_NOISE: begin
                  noise_angle = csr_wdata;
                  clear_filter();
               end
               REG_BIAS_NOISE: begin
                  noise_bias = csr_wdata;
                  clear_filter();
               end
               REG_MEAS_NOISE: begin
                  noise_meas = csr_wdata;
                  clear_filter();
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.angle = rsp_angle_estimate;
            got.bias  = rsp_bias_estimate;
            got.rate  = rsp_corrected_rate;
            if (estimate_q.size() == 0) begin
               report_mismatch("unexpected result", got.angle, '0);
            end else begin
               want = estimate_q.pop_front();
               if (got.angle !== want.angle) report_mismatch("angle", got.angle, want.angle);
               if (got.bias !== want.bias) report_mismatch("bias", got.bias, want.bias);
               if (got.rate !== want.rate) report_mismatch("rate", got.rate, want.rate);
            end
         end
      end
   end

   // The receiver switches between three moods: it never stalls, it stalls at
   // random, or it stalls most of the time. Once the main flow asks for it, the
   // receiver also holds off for one long stretch. The sender keeps offering
   // beats during that stretch, so the block fills up and stalls its input.
   int unsigned mood;
   int unsigned mood_left;
   int unsigned hold_left;
   bit          hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         mood_left <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         if (mood_left == 0) begin
            mood      <= $urandom_range(0, 2);
            mood_left <= $urandom_range(64, 512);
         end else begin
            mood_left <= mood_left - 1;
         end
         case (mood)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // This task is called right after a rising edge. The beat is offered at that
   // edge, and the task returns on the edge at which the beat is accepted.
   task automatic send_sample(input logic [31:0] z, input logic [31:0] w,
                              input logic [15:0] dt, input bit typed,
                              input filter_out_type result);
      req_valid           <= 1'b1;
      req_measured_angle  <= z;
      req_measured_rate   <= w;
      req_sample_interval <= dt;
      drv_typed           <= typed;
      drv_result          <= result;
      do @(posedge clock); while (req_stall);
   endtask

   // A register is written only while the block is idle. The wait for an empty
   // queue also pauses the sender until every expected result has come. One edge
   // passes first so that the last accepted beat is surely in the queue.
   task automatic write_reg(input logic [1:0] index, input logic [30:0] wdata);
      req_valid <= 1'b0;
      @(posedge clock);
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [30:0] pick_noise();
      int unsigned c;
      c = $urandom_range(0, 19);
      if (c == 0) return '0;
      if (c == 1) return NOISE_MAX;
      if (c < 5) return 31'($urandom());
      return 31'($urandom_range(0, 1 << 24));
   endfunction

   stim_row_type table_rows[$];

   task automatic add_item(input logic [31:0] z, input logic [31:0] w, input logic [15:0] dt,
                           input bit typed, input logic [31:0] ea, input logic [31:0] eb,
                           input logic [31:0] er);
      stim_row_type row;
      row.kind   = ROW_ITEM;
      row.index  = '0;
      row.wdata  = '0;
      row.angle  = z;
      row.rate   = w;
      row.dt     = dt;
      row.typed  = typed;
      row.result = {ea, eb, er};
      table_rows.push_back(row);
   endtask

   task automatic add_csr(input logic [1:0] index, input logic [30:0] wdata);
      stim_row_type row;
      row.kind   = ROW_CSR;
      row.index  = index;
      row.wdata  = wdata;
      row.angle  = '0;
      row.rate   = '0;
      row.dt     = '0;
      row.typed  = 1'b0;
      row.result = '0;
      table_rows.push_back(row);
   endtask

   initial begin
      int unsigned burst_left;
      logic [31:0] z;
      logic [31:0] w;
      logic [15:0] dt;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_measured_angle  = '0;
      req_measured_rate   = '0;
      req_sample_interval = '0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      drv_typed           = 1'b0;
      drv_result          = '0;
      rsp_stall           = 1'b0;
      cycle_count         = 0;
      err_count           = 0;
      hold_go             = 1'b0;
      noise_angle         = ANGLE_NOISE_RESET;
      noise_bias          = BIAS_NOISE_RESET;
      noise_meas          = MEAS_NOISE_RESET;
      clear_filter();

      // From a cleared state with dt at zero, the covariance stays at zero. The
      // gains are then zero, and the result is a zero angle, a zero bias and the
      // raw gyro rate.
      add_item(32'h7fffffff, 32'h80000000, 16'h0000, 1, 32'h0, 32'h0, 32'h80000000);
      add_item(32'h80000000, 32'h7fffffff, 16'h0000, 1, 32'h0, 32'h0, 32'h7fffffff);
      add_item(32'h00000000, 32'h00000000, 16'h0000, 1, 32'h0, 32'h0, 32'h00000000);
      add_item(32'h00640000, 32'h00010000, 16'h0041, 0, '0, '0, '0);
      add_item(32'h7fffffff, 32'h7fffffff, 16'hffff, 0, '0, '0, '0);
      add_item(32'h80000000, 32'h80000000, 16'hffff, 0, '0, '0, '0);
      add_item(32'h12345678, 32'hedcba987, 16'h8000, 0, '0, '0, '0);
      // With zero measurement noise and a cleared covariance, the innovation
      // covariance is zero and the correction is skipped.
      add_csr(REG_MEAS_NOISE, '0);
      add_item(32'h00001000, 32'h00002000, 16'h0000, 1, 32'h0, 32'h0, 32'h00002000);
      add_item(32'hffffffff, 32'hffffffff, 16'h0000, 1, 32'h0, 32'h0, 32'hffffffff);
      add_item(32'h00500000, 32'hfff00000, 16'h0100, 0, '0, '0, '0);
      // All noise values at their maximum push the covariance into saturation.
      add_csr(REG_ANGLE_NOISE, NOISE_MAX);
      add_csr(REG_BIAS_NOISE, NOISE_MAX);
      add_csr(REG_MEAS_NOISE, NOISE_MAX);
      add_item(32'h7fffffff, 32'h80000000, 16'hffff, 0, '0, '0, '0);
      add_item(32'h80000000, 32'h7fffffff, 16'hffff, 0, '0, '0, '0);
      add_item(32'h55555555, 32'haaaaaaaa, 16'hffff, 0, '0, '0, '0);
      // A write to the index with no register must leave the state alone.
      add_csr(REG_UNUSED, 31'h55555555);
      add_item(32'h2aaaaaaa, 32'hd5555555, 16'h5555, 0, '0, '0, '0);
      add_csr(REG_ANGLE_NOISE, '0);
      add_csr(REG_BIAS_NOISE, '0);
      add_csr(REG_MEAS_NOISE, '0);
      add_item(32'h01000000, 32'h00400000, 16'hffff, 0, '0, '0, '0);
      add_item(32'hff000000, 32'hffc00000, 16'h0001, 0, '0, '0, '0);
      add_csr(REG_ANGLE_NOISE, ANGLE_NOISE_RESET);
      add_csr(REG_BIAS_NOISE, BIAS_NOISE_RESET);
      add_csr(REG_MEAS_NOISE, MEAS_NOISE_RESET);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         if (table_rows[i].kind == ROW_CSR) begin
            write_reg(table_rows[i].index, table_rows[i].wdata);
         end else begin
            send_sample(table_rows[i].angle, table_rows[i].rate, table_rows[i].dt,
                        table_rows[i].typed, table_rows[i].result);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_reg(REG_ANGLE_NOISE, pick_noise());
         write_reg(REG_BIAS_NOISE, pick_noise());
         write_reg(REG_MEAS_NOISE, pick_noise());
         if (ph == 1) hold_go = 1'b1;
         burst_left = $urandom_range(1, 12);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Most samples look like a real sensor: small angles and rates with
            // millisecond intervals. The rest use the whole range of every field.
            if ($urandom_range(0, 9) < 8) begin
               z  = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
               w  = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
               dt = 16'($urandom_range(16, 2000));
            end else begin
               z  = $urandom();
               w  = $urandom();
               dt = 16'($urandom());
            end
            send_sample(z, w, dt, 1'b0, '0);
            burst_left--;
            if (burst_left == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 40)) @(posedge clock);
               burst_left = $urandom_range(1, 12);
            end
         end
         req_valid <= 1'b0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (estimate_q.size() != 0) report_mismatch("missing result", '0, '0);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: angle_bias_kalman_filter_top.f
hdl/abkf_pkg.sv
hdl/abkf_div.sv
hdl/abkf_dpath.sv
hdl/abkf_ctrl.sv
hdl/angle_bias_kalman_filter_top.sv
tb/sv/angle_bias_kalman_filter_top_test.sv
